/* rtl/ptb_pkg.sv */
`timescale 1ns / 1ps
package ptb_pkg;

	// default sizing
	localparam int MAX_TEXT_DEF = 4096;
	localparam int ALPHABET_DEF = 10;

	// fixed field widths
	localparam int COUNT_W = 13;
	localparam int INDEX_W = 13;
	localparam int LENGTH_W = 14;
	localparam int CFG_W = 13;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// opcodes
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_PROPAGATE = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK_RD,
		S_WALK_CMP,
		S_CHILD_RD,
		S_BUMP_RD,
		S_LINK_RD,
		S_PROP_N,
		S_PROP_P,
		S_READ_RD,
		S_EMIT
	} state_t;

	// saturating count add
	function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
			input logic [COUNT_W-1:0] b);
		logic [COUNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
	endfunction

endpackage

/* rtl/ptb_ram.sv */
`timescale 1ns / 1ps
module ptb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* rtl/palindromic_tree_builder_top.sv */
`timescale 1ns / 1ps
// an append walks the suffix links one step at a time; a propagate visits every node above node 1
// one item in flight: the next input can be taken in the same cycle the result is offered
// reset is asynchronous; it starts a clearing pass over the child and node memories,
// during which no item is taken
module palindromic_tree_builder_top #(
	parameter int MAX_TEXT = ptb_pkg::MAX_TEXT_DEF,
	parameter int ALPHABET = ptb_pkg::ALPHABET_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [ptb_pkg::CFG_W-1:0]      cfg_write_data,
	input  logic                           op_valid,
	output logic                           op_ready,
	input  logic [1:0]                     opcode,
	input  logic [3:0]                     digit,
	input  logic [ptb_pkg::INDEX_W-1:0]    node_select,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [1:0]                     status,
	output logic                           created,
	output logic [ptb_pkg::INDEX_W-1:0]    node_index,
	output logic signed [ptb_pkg::LENGTH_W-1:0] node_length,
	output logic [ptb_pkg::INDEX_W-1:0]    suffix_link,
	output logic [ptb_pkg::COUNT_W-1:0]    total_count,
	output logic [ptb_pkg::COUNT_W-1:0]    first_part_count
);
	import ptb_pkg::*;

	localparam int NODE_DEPTH = MAX_TEXT + 2;
	localparam int NW = $clog2(NODE_DEPTH);
	localparam int NTW = $clog2(NODE_DEPTH + 1);
	localparam int LW = NW + 1;
	localparam int PW = $clog2(MAX_TEXT + 1);
	localparam int TW = $clog2(MAX_TEXT);
	localparam int SW = $clog2(ALPHABET);
	localparam int CH_DEPTH = NODE_DEPTH * ALPHABET;
	localparam int CHW = $clog2(CH_DEPTH);
	localparam int IW = NW + 2;
	localparam int CW = COUNT_W;
	localparam int NODE_W = LW + NW + 2 * CW;

	state_t state_q, state_d;

	logic [CFG_W-1:0] cfg_q;
	logic [NTW-1:0]   node_total_q;
	logic [NW-1:0]    last_q;
	logic [PW-1:0]    pos_q;
	logic [CHW-1:0]   clr_q;

	logic [NW-1:0]        u_q, v_q, n_q, p_q;
	logic signed [LW-1:0] lenu_q, lenv_q;
	logic [NW-1:0]        linku_q;
	logic                 walk2_q, in_first_q;
	logic [SW-1:0]        ch_q;
	logic [CW-1:0]        totn_q, firstn_q, fwd_tot_q, fwd_first_q;
	logic                 fwd_q;

	logic [1:0]           r_status_q;
	logic                 r_created_q;
	logic [NW-1:0]        r_index_q, r_link_q;
	logic signed [LW-1:0] r_len_q;
	logic [CW-1:0]        r_tot_q, r_first_q;

	logic                 out_valid_q;
	logic [1:0]           o_status_q;
	logic                 o_created_q;
	logic [NW-1:0]        o_index_q, o_link_q;
	logic signed [LW-1:0] o_len_q;
	logic [CW-1:0]        o_tot_q, o_first_q;

	// memory ports
	logic              txt_we, txt_re;
	logic [TW-1:0]     txt_waddr, txt_raddr;
	logic [SW-1:0]     txt_wdata, txt_rdata;
	logic              nd_we, nd_re;
	logic [NW-1:0]     nd_waddr, nd_raddr;
	logic [NODE_W-1:0] nd_wdata, nd_rdata;
	logic              ch_we, ch_re;
	logic [CHW-1:0]    ch_waddr, ch_raddr;
	logic [NW-1:0]     ch_wdata, ch_rdata;

	// node word fields
	logic signed [LW-1:0] nd_len;
	logic [NW-1:0]        nd_link;
	logic [CW-1:0]        nd_tot, nd_first;

	assign nd_len = $signed(nd_rdata[NODE_W-1 -: LW]);
	assign nd_link = nd_rdata[2*CW +: NW];
	assign nd_tot = nd_rdata[CW +: CW];
	assign nd_first = nd_rdata[0 +: CW];

	logic               accept, out_free, pos_full, sel_missing, idx_ok, txt_match;
	logic               clr_last, sel_in_range;
	logic [3:0]         fold;
	logic [SW-1:0]      ch_in;
	logic signed [IW-1:0] idx;
	logic [NW-1:0]      v_new;
	logic [CW-1:0]      bump_tot, bump_first, prop_tot, prop_first, n_tot, n_first;
	logic [NW-1:0]      sel_node;
	int                 k;

	assign op_ready = (state_q == S_IDLE);
	assign accept = op_valid && op_ready;
	assign out_free = !out_valid_q || res_ready;
	assign pos_full = 32'(pos_q) >= MAX_TEXT;
	assign sel_missing = 32'(node_select) >= 32'(node_total_q);
	assign sel_node = NW'(node_select);
	assign clr_last = 32'(clr_q) == CH_DEPTH - 1;
	assign sel_in_range = 32'(clr_q) < NODE_DEPTH;
	assign v_new = node_total_q[NW-1:0];
	assign txt_match = (txt_rdata == ch_q);

	// reduce the symbol into the alphabet
	always_comb begin
		fold = digit;
		for (k = 0; k < 8; k++) begin
			if (32'(fold) >= ALPHABET) begin
				fold = fold - 4'(ALPHABET);
			end
		end
		ch_in = SW'(fold);
	end

	// mirror position of the candidate palindrome
	always_comb begin
		idx = $signed({{(IW - PW){1'b0}}, pos_q}) - $signed(IW'(1)) - IW'(nd_len);
		idx_ok = !idx[IW-1] && (idx < $signed(IW'(MAX_TEXT)));
	end

	// count updates
	always_comb begin
		bump_tot = sat_add(nd_tot, CW'(1));
		bump_first = in_first_q ? sat_add(nd_first, CW'(1)) : nd_first;
		n_tot = fwd_q ? fwd_tot_q : nd_tot;
		n_first = fwd_q ? fwd_first_q : nd_first;
		prop_tot = sat_add(nd_tot, totn_q);
		prop_first = sat_add(nd_first, firstn_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (op_valid) begin
					case (opcode)
						OP_APPEND: state_d = pos_full ? S_EMIT : S_WALK_RD;
						OP_PROPAGATE: state_d = (32'(node_total_q) > 2) ? S_PROP_N : S_EMIT;
						OP_READ: state_d = sel_missing ? S_EMIT : S_READ_RD;
						default: state_d = S_EMIT;
					endcase
				end
			end
			S_WALK_RD: begin
				if (idx_ok) begin
					state_d = S_WALK_CMP;
				end
			end
			S_WALK_CMP: begin
				if (txt_match) begin
					state_d = walk2_q ? S_LINK_RD : S_CHILD_RD;
				end else begin
					state_d = S_WALK_RD;
				end
			end
			S_CHILD_RD: begin
				if (ch_rdata != '0) begin
					state_d = S_BUMP_RD;
				end else if (lenu_q == -1) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_WALK_RD;
				end
			end
			S_BUMP_RD: state_d = S_EMIT;
			S_LINK_RD: state_d = S_EMIT;
			S_PROP_N: state_d = S_PROP_P;
			S_PROP_P: state_d = (32'(n_q) == 2) ? S_EMIT : S_PROP_N;
			S_READ_RD: state_d = S_EMIT;
			S_EMIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		txt_we = 1'b0;
		txt_waddr = pos_q[TW-1:0];
		txt_wdata = ch_in;
		txt_re = 1'b0;
		txt_raddr = idx[TW-1:0];
		nd_we = 1'b0;
		nd_waddr = v_q;
		nd_wdata = '0;
		nd_re = 1'b0;
		nd_raddr = u_q;
		ch_we = 1'b0;
		ch_waddr = CHW'(CHW'(u_q) * CHW'(ALPHABET) + CHW'(ch_q));
		ch_wdata = v_new;
		ch_re = 1'b0;
		ch_raddr = CHW'(CHW'(u_q) * CHW'(ALPHABET) + CHW'(ch_q));
		case (state_q)
			S_CLEAR: begin
				ch_we = 1'b1;
				ch_waddr = clr_q;
				ch_wdata = '0;
				nd_we = sel_in_range;
				nd_waddr = NW'(clr_q);
				nd_wdata = (clr_q == '0) ? {LW'(-1), {(NODE_W - LW){1'b0}}} : '0;
			end
			S_IDLE: begin
				if (accept) begin
					case (opcode)
						OP_APPEND: begin
							txt_we = !pos_full;
							nd_re = !pos_full;
							nd_raddr = last_q;
						end
						OP_PROPAGATE: begin
							nd_re = 1'b1;
							nd_raddr = NW'(node_total_q - NTW'(1));
						end
						OP_READ: begin
							nd_re = !sel_missing;
							nd_raddr = sel_node;
						end
						default: ;
					endcase
				end
			end
			S_WALK_RD: begin
				if (idx_ok) begin
					txt_re = 1'b1;
				end else begin
					nd_re = 1'b1;
					nd_raddr = nd_link;
				end
			end
			S_WALK_CMP: begin
				if (txt_match) begin
					ch_re = 1'b1;
				end else begin
					nd_re = 1'b1;
					nd_raddr = linku_q;
				end
			end
			S_CHILD_RD: begin
				if (ch_rdata != '0) begin
					nd_re = 1'b1;
					nd_raddr = ch_rdata;
				end else begin
					ch_we = 1'b1;
					if (lenu_q == -1) begin
						nd_we = 1'b1;
						nd_waddr = v_new;
						nd_wdata = {LW'(1), NW'(1), CW'(1), CW'(in_first_q)};
					end else begin
						nd_re = 1'b1;
						nd_raddr = linku_q;
					end
				end
			end
			S_BUMP_RD: begin
				nd_we = 1'b1;
				nd_wdata = {nd_len, nd_link, bump_tot, bump_first};
			end
			S_LINK_RD: begin
				nd_we = 1'b1;
				nd_wdata = {lenv_q, ch_rdata, CW'(1), CW'(in_first_q)};
			end
			S_PROP_N: begin
				nd_re = 1'b1;
				nd_raddr = nd_link;
			end
			S_PROP_P: begin
				nd_we = 1'b1;
				nd_waddr = p_q;
				nd_wdata = {nd_len, nd_link, prop_tot, prop_first};
				if (32'(n_q) != 2) begin
					nd_re = 1'b1;
					nd_raddr = n_q - NW'(1);
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			cfg_q <= '0;
			node_total_q <= NTW'(2);
			last_q <= NW'(1);
			pos_q <= '0;
			out_valid_q <= 1'b0;
			fwd_q <= 1'b0;
			walk2_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write_en) begin
				cfg_q <= cfg_write_data;
			end
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + CHW'(1);
			end
			if (state_q == S_IDLE) begin
				walk2_q <= 1'b0;
			end
			if (state_q == S_CHILD_RD && ch_rdata == '0) begin
				node_total_q <= node_total_q + NTW'(1);
				walk2_q <= 1'b1;
				if (lenu_q == -1) begin
					last_q <= v_new;
					pos_q <= pos_q + PW'(1);
				end
			end
			if (state_q == S_BUMP_RD || state_q == S_LINK_RD) begin
				last_q <= v_q;
				pos_q <= pos_q + PW'(1);
			end
			// forward only into the next node of the same pass
			if (state_q == S_PROP_P) begin
				fwd_q <= (p_q == n_q - NW'(1)) && (32'(n_q) != 2);
			end else if (state_q == S_PROP_N) begin
				fwd_q <= 1'b0;
			end
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				u_q <= last_q;
				ch_q <= ch_in;
				in_first_q <= 32'(pos_q) < 32'(cfg_q);
				n_q <= (opcode == OP_READ) ? sel_node : NW'(node_total_q - NTW'(1));
				r_status_q <= ST_OK;
				r_created_q <= 1'b0;
				r_index_q <= '0;
				r_len_q <= '0;
				r_link_q <= '0;
				r_tot_q <= '0;
				r_first_q <= '0;
				if (opcode == OP_APPEND && pos_full) begin
					r_status_q <= ST_FULL;
				end
				if (opcode == OP_READ && sel_missing) begin
					r_status_q <= ST_MISSING;
				end
			end
			S_WALK_RD: begin
				lenu_q <= nd_len;
				linku_q <= nd_link;
				if (!idx_ok) begin
					u_q <= nd_link;
				end
			end
			S_WALK_CMP: begin
				if (!txt_match) begin
					u_q <= linku_q;
				end
			end
			S_CHILD_RD: begin
				if (ch_rdata != '0) begin
					v_q <= ch_rdata;
				end else begin
					v_q <= v_new;
					lenv_q <= lenu_q + LW'(2);
					u_q <= linku_q;
					r_created_q <= 1'b1;
					r_index_q <= v_new;
					r_len_q <= LW'(1);
					r_link_q <= NW'(1);
					r_tot_q <= CW'(1);
					r_first_q <= CW'(in_first_q);
				end
			end
			S_BUMP_RD: begin
				r_index_q <= v_q;
				r_len_q <= nd_len;
				r_link_q <= nd_link;
				r_tot_q <= bump_tot;
				r_first_q <= bump_first;
			end
			S_LINK_RD: begin
				r_index_q <= v_q;
				r_len_q <= lenv_q;
				r_link_q <= ch_rdata;
			end
			S_PROP_N: begin
				p_q <= nd_link;
				totn_q <= n_tot;
				firstn_q <= n_first;
			end
			S_PROP_P: begin
				n_q <= n_q - NW'(1);
				fwd_tot_q <= prop_tot;
				fwd_first_q <= prop_first;
			end
			S_READ_RD: begin
				r_index_q <= n_q;
				r_len_q <= nd_len;
				r_link_q <= nd_link;
				r_tot_q <= nd_tot;
				r_first_q <= nd_first;
			end
			default: ;
		endcase
		// output register takes the finished result
		if (state_q == S_EMIT && out_free) begin
			o_status_q <= r_status_q;
			o_created_q <= r_created_q;
			o_index_q <= r_index_q;
			o_len_q <= r_len_q;
			o_link_q <= r_link_q;
			o_tot_q <= r_tot_q;
			o_first_q <= r_first_q;
		end
	end

	assign res_valid = out_valid_q;
	assign status = o_status_q;
	assign created = o_created_q;
	assign node_index = INDEX_W'(o_index_q);
	assign node_length = LENGTH_W'(o_len_q);
	assign suffix_link = INDEX_W'(o_link_q);
	assign total_count = o_tot_q;
	assign first_part_count = o_first_q;

	// memories
	ptb_ram #(.WIDTH(SW), .DEPTH(MAX_TEXT)) u_text (
		.clk(clk), .we(txt_we), .waddr(txt_waddr), .wdata(txt_wdata),
		.re(txt_re), .raddr(txt_raddr), .rdata(txt_rdata)
	);

	ptb_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_node (
		.clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
		.re(nd_re), .raddr(nd_raddr), .rdata(nd_rdata)
	);

	ptb_ram #(.WIDTH(NW), .DEPTH(CH_DEPTH)) u_child (
		.clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
		.re(ch_re), .raddr(ch_raddr), .rdata(ch_rdata)
	);

	// checks
	a_node_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(node_total_q) >= 2) && (32'(node_total_q) <= NODE_DEPTH))
		else $error("node total out of range");

	a_last_exists: assert property (@(posedge clk) disable iff (!arst_n)
		32'(last_q) < 32'(node_total_q))
		else $error("last node not yet created");

	a_child_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(ch_we && state_q != S_CLEAR) |-> (ch_wdata != '0))
		else $error("child link written as empty");

	a_missing_read: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_READ && sel_missing) |=> (state_q == S_EMIT))
		else $error("read of missing node went to memory");
endmodule
